FILE: hdl/rke_pkg.sv
// shared types and constants for the rolling k-mer extractor
package rke_pkg;

  localparam int unsigned MaxReadLen = 65536;
  localparam int unsigned PosW       = $clog2(MaxReadLen + 1);
  localparam int unsigned StartW     = 16;
  localparam int unsigned KmerMax    = 16;
  localparam int unsigned KLenW      = 5;
  localparam int unsigned WordW      = 2 * KmerMax;
  localparam int unsigned RunW       = $clog2(KmerMax + 1);

  localparam logic [KLenW-1:0] KLenReset = KLenW'(8);
  localparam logic [PosW-1:0]  PosLimit  = PosW'(MaxReadLen);

  typedef enum logic [1:0] {
    BaseA = 2'd0,
    BaseC = 2'd1,
    BaseG = 2'd2,
    BaseT = 2'd3
  } base_e;

  typedef struct packed {
    logic  is_base;
    base_e code;
  } base_t;

  typedef struct packed {
    logic              kmer_valid;
    logic [StartW-1:0] kmer_start;
    logic [WordW-1:0]  kmer_code;
    logic              read_done;
  } kmer_res_t;

endpackage

FILE: hdl/rke_base_decode.sv
// maps an ascii character to its 2-bit base code or a break
module rke_base_decode (
  input  logic [7:0]     base_char_i,
  output rke_pkg::base_t base_o
);

  always_comb begin
    base_o.is_base = 1'b1;
    base_o.code    = rke_pkg::BaseA;
    unique case (base_char_i)
      "A", "a": base_o.code = rke_pkg::BaseA;
      "C", "c": base_o.code = rke_pkg::BaseC;
      "G", "g": base_o.code = rke_pkg::BaseG;
      "T", "t": base_o.code = rke_pkg::BaseT;
      default: begin
        base_o.is_base = 1'b0;
        base_o.code    = rke_pkg::BaseA;
      end
    endcase
  end

endmodule

FILE: hdl/rke_kmer_core.sv
// read state registers and the per-base k-mer update
module rke_kmer_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [rke_pkg::KLenW-1:0] kmer_length_i,
  input  rke_pkg::base_t            base_i,
  input  logic                      end_of_read_i,
  output rke_pkg::kmer_res_t        res_o
);

  logic [rke_pkg::WordW-1:0] word_q, word_d;
  logic [rke_pkg::RunW-1:0]  run_q, run_d;
  logic [rke_pkg::PosW-1:0]  pos_q, pos_d;
  logic [rke_pkg::KLenW-1:0] k_eff;
  logic [5:0]                shamt;
  logic [rke_pkg::WordW-1:0] mask;
  logic [rke_pkg::PosW-1:0]  start_full;
  logic                      pos_ok;

  always_comb begin
    priority if (kmer_length_i == '0) begin
      k_eff = rke_pkg::KLenW'(1);
    end else if (kmer_length_i > rke_pkg::KLenW'(rke_pkg::KmerMax)) begin
      k_eff = rke_pkg::KLenW'(rke_pkg::KmerMax);
    end else begin
      k_eff = kmer_length_i;
    end
  end

  assign shamt = {k_eff, 1'b0};
  assign mask  = ~({rke_pkg::WordW{1'b1}} << shamt);
  assign pos_ok = (pos_q < rke_pkg::PosLimit);
  assign start_full = pos_q + rke_pkg::PosW'(1) - rke_pkg::PosW'(k_eff);

  always_comb begin
    word_d = word_q;
    run_d  = '0;
    if (base_i.is_base) begin
      word_d = {word_q[rke_pkg::WordW-3:0], base_i.code};
      run_d  = (run_q < rke_pkg::RunW'(rke_pkg::KmerMax)) ? run_q + rke_pkg::RunW'(1) : run_q;
    end
  end

  always_comb begin
    res_o            = '0;
    res_o.read_done  = end_of_read_i;
    if (base_i.is_base && pos_ok && (rke_pkg::KLenW'(run_d) >= k_eff)) begin
      res_o.kmer_valid = 1'b1;
      res_o.kmer_start = start_full[rke_pkg::StartW-1:0];
      res_o.kmer_code  = word_d & mask;
    end
  end

  assign pos_d = pos_ok ? pos_q + rke_pkg::PosW'(1) : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      run_q  <= '0;
      pos_q  <= '0;
    end else if (step_i) begin
      if (end_of_read_i) begin
        word_q <= '0;
        run_q  <= '0;
        pos_q  <= '0;
      end else begin
        word_q <= word_d;
        run_q  <= run_d;
        pos_q  <= pos_d;
      end
    end
  end

endmodule

FILE: hdl/rolling_kmer_extractor.sv
// top level of the rolling k-mer extractor
// usage:
// - input channel in_valid_i/in_ready_o carries one ascii base per request
//   with end_of_read_i set on the last character of a read
// - output channel out_valid_o/out_ready_i carries exactly one result per
//   input request; kmer_valid_o tells whether a k-mer ends at that base
// - cfg_we_i/cfg_wdata_i set the k-mer length (0 acts as 1, above 16 as 16);
//   write it only while no request is in flight
// - an accepted request is loaded into the input register; the state update
//   and mask logic then run from it into the result register, which drives
//   the outputs
// - throughput is one base per cycle while the receiver takes each result,
//   with the rolling shift and run counter update done per accepted base
// - when the receiver stalls, the result register holds and the input
//   register fills; the input side stops only when both are occupied
// - reset clears the pipeline, the read state and sets the length to 8;
//   read state also clears after each end-of-read request
module rolling_kmer_extractor (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rke_pkg::KLenW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                base_char_i,
  input  logic                      end_of_read_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      kmer_valid_o,
  output logic [15:0]               kmer_start_o,
  output logic [31:0]               kmer_code_o,
  output logic                      read_done_o
);

  logic [rke_pkg::KLenW-1:0] klen_q;
  logic                      in_vld_q;
  logic [7:0]                char_q;
  logic                      eor_q;
  logic                      out_vld_q;
  rke_pkg::kmer_res_t        res_q, res_d;
  rke_pkg::base_t            base;
  logic                      advance;

  assign advance    = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= rke_pkg::KLenReset;
    end else if (cfg_we_i) begin
      klen_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= base_char_i;
      eor_q  <= end_of_read_i;
    end
  end

  rke_base_decode u_decode (
    .base_char_i (char_q),
    .base_o      (base)
  );

  rke_kmer_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_vld_q && advance),
    .kmer_length_i (klen_q),
    .base_i        (base),
    .end_of_read_i (eor_q),
    .res_o         (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign kmer_valid_o = res_q.kmer_valid;
  assign kmer_start_o = res_q.kmer_start;
  assign kmer_code_o  = res_q.kmer_code;
  assign read_done_o  = res_q.read_done;

endmodule
